### sv/ddog_pkg.sv
// Shared constants, types and tables for the odometry and go-to-goal block.
package ddog_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int POS_BITS_DEF = 24;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_MOVE = 2'd1;
  localparam logic [1:0] OP_STOP = 2'd2;
  localparam logic [1:0] OP_RESET_POSE = 2'd3;

  localparam logic [2:0] REG_BASE_DRIVE = 3'd0;
  localparam logic [2:0] REG_STEER_GAIN = 3'd1;
  localparam logic [2:0] REG_ARRIVE_RADIUS = 3'd2;
  localparam logic [2:0] REG_TICK_LENGTH = 3'd3;
  localparam logic [2:0] REG_TURN_PER_TICK = 3'd4;

  localparam logic signed [31:0] KGAIN_Q30 = 32'sd652032874;
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

  // datapath commands from the controller
  typedef struct packed {
    logic load_item;    // latch opcode and ticks, apply tick accumulation
    logic start_move;   // prepare travel and midpoint heading
    logic sc_init;      // load sin/cos CORDIC
    logic sc_step;
    logic mul_pos;      // travel times cos/sin
    logic upd_pos;      // add position step, update heading
    logic diff_pos;     // offset to the target
    logic arrive;       // zero the drives, go idle, flag reached
    logic at_init;      // load atan2 CORDIC
    logic at_step;
    logic steer_mul;    // gain times error
    logic steer_fin;    // drives from product
    logic simple;       // non-tick opcodes and ticks while not moving
  } ddog_cmd_t;

  typedef struct packed {
    logic tick_run;     // tick arriving while moving
    logic step_last;    // last CORDIC iteration
    logic arrived;      // inside arrival radius
  } ddog_sts_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
        5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
        5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
        5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
        5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
        5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
        5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
        5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
        5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction

endpackage

### sv/ddog_ctrl.sv
// Controller sequencing one item through the odometry datapath.
module ddog_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  ddog_pkg::ddog_sts_t sts,
  output ddog_pkg::ddog_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_PREP = 4'd2;
  localparam logic [3:0] S_SC = 4'd3;
  localparam logic [3:0] S_MULP = 4'd4;
  localparam logic [3:0] S_UPD = 4'd5;
  localparam logic [3:0] S_DIFF = 4'd6;
  localparam logic [3:0] S_CHECK = 4'd7;
  localparam logic [3:0] S_AT = 4'd8;
  localparam logic [3:0] S_SMUL = 4'd9;
  localparam logic [3:0] S_SFIN = 4'd10;
  localparam logic [3:0] S_OUT = 4'd11;

  logic [3:0] state, state_next;

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.tick_run) begin
          cmd.start_move = 1'b1;
          state_next = S_PREP;
        end else begin
          cmd.simple = 1'b1;
          state_next = S_OUT;
        end
      end
      S_PREP: begin
        cmd.sc_init = 1'b1;
        state_next = S_SC;
      end
      S_SC: begin
        cmd.sc_step = 1'b1;
        if (sts.step_last) state_next = S_MULP;
      end
      S_MULP: begin
        cmd.mul_pos = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd_pos = 1'b1;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff_pos = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.arrived) begin
          cmd.arrive = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.at_init = 1'b1;
          state_next = S_AT;
        end
      end
      S_AT: begin
        cmd.at_step = 1'b1;
        if (sts.step_last) state_next = S_SMUL;
      end
      S_SMUL: begin
        cmd.steer_mul = 1'b1;
        state_next = S_SFIN;
      end
      S_SFIN: begin
        cmd.steer_fin = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

### sv/ddog_dp.sv
// Datapath: pose state, shared CORDIC, distance test and steering arithmetic.
module ddog_dp #(
  parameter int CORDIC_STEPS = ddog_pkg::CORDIC_STEPS_DEF,
  parameter int POS_BITS = ddog_pkg::POS_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ddog_pkg::ddog_cmd_t cmd,
  output ddog_pkg::ddog_sts_t sts,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [11:0]         cfg_data,
  input  logic [1:0]          opcode,
  input  logic [7:0]          left_ticks,
  input  logic [7:0]          right_ticks,
  input  logic signed [23:0]  goal_x,
  input  logic signed [23:0]  goal_y,
  output logic signed [8:0]   left_drive,
  output logic signed [8:0]   right_drive,
  output logic signed [23:0]  pose_x,
  output logic signed [23:0]  pose_y,
  output logic signed [15:0]  heading,
  output logic                moving,
  output logic                reached
);

  localparam int AW = (POS_BITS > 24) ? POS_BITS : 24;  // target width
  localparam int DW = AW + 2;   // difference width
  localparam int CW = DW + 26;  // CORDIC vector width, atan2 input scaled by 2^24
  localparam int SW = 34;       // position sum width before saturation
  localparam logic signed [POS_BITS-1:0] PMAX = {1'b0, {(POS_BITS-1){1'b1}}};
  localparam logic signed [POS_BITS-1:0] PMIN = {1'b1, {(POS_BITS-1){1'b0}}};

  logic [7:0] base_drive, arrive_radius;
  logic [9:0] steer_gain;
  logic [11:0] tick_length, turn_per_tick;

  logic signed [POS_BITS-1:0] pos_x, pos_y;
  logic signed [AW-1:0] aim_x, aim_y;
  logic [15:0] head_angle, pend_l, pend_r;
  logic run_mode, reach;
  logic signed [8:0] drv_l, drv_r;
  logic [1:0] op;

  logic [27:0] travel;
  logic signed [28:0] dang;
  logic signed [CW-1:0] cx, cy;
  logic signed [33:0] cz;
  logic flip;
  logic [4:0] it;
  logic signed [60:0] mx, my;
  logic signed [DW-1:0] dx, dy;
  logic signed [27:0] gp;

  // combinational helpers
  logic [16:0] sum_l, sum_r;
  logic signed [CW-1:0] shx, shy, vx, vy;
  logic [31:0] at_k;
  logic signed [33:0] z0;
  logic [15:0] mid, err;
  logic signed [31:0] cs, sn;
  logic [DW-1:0] ax, ay;
  logic [2*DW-1:0] dsq;
  logic [15:0] lim;
  logic [31:0] limsq;
  logic signed [SW-1:0] pxs, pys;
  logic signed [63:0] pfull, bb, bl, br;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      base_drive <= 8'd150;
      steer_gain <= 10'd150;
      arrive_radius <= 8'd5;
      tick_length <= 12'd261;
      turn_per_tick <= 12'd710;
    end else if (cfg_we) begin
      case (cfg_index)
        ddog_pkg::REG_BASE_DRIVE: base_drive <= cfg_data[7:0];
        ddog_pkg::REG_STEER_GAIN: steer_gain <= cfg_data[9:0];
        ddog_pkg::REG_ARRIVE_RADIUS: arrive_radius <= cfg_data[7:0];
        ddog_pkg::REG_TICK_LENGTH: tick_length <= cfg_data;
        ddog_pkg::REG_TURN_PER_TICK: turn_per_tick <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic signed [8:0] sat_drv(input logic signed [63:0] v);
    logic signed [63:0] t;
    begin
      // truncate toward zero by 2^45
      if (v < 0) t = -((-v) >>> 45);
      else t = v >>> 45;
      if (t > 255) return 9'sd255;
      else if (t < -255) return -9'sd255;
      else return t[8:0];
    end
  endfunction

  always_comb begin
    sum_l = {1'b0, pend_l} + {9'd0, left_ticks};
    sum_r = {1'b0, pend_r} + {9'd0, right_ticks};
    shx = cx >>> it;
    shy = cy >>> it;
    at_k = ddog_pkg::atan_turn(it);
    mid = head_angle + dang[16:1];
    z0 = {{2{mid[15]}}, mid, 16'd0};
    vx = CW'(dx) <<< 24;
    vy = CW'(dy) <<< 24;
    cs = $signed(cx[31:0]);
    sn = $signed(cy[31:0]);
    pxs = SW'(pos_x) + SW'($signed(mx[60:30]));
    pys = SW'(pos_y) + SW'($signed(my[60:30]));
    ax = dx[DW-1] ? -dx : dx;
    ay = dy[DW-1] ? -dy : dy;
    dsq = (2*DW)'(ax) * (2*DW)'(ax) + (2*DW)'(ay) * (2*DW)'(ay);
    lim = {arrive_radius, 8'd0};
    limsq = 32'(lim) * 32'(lim);
    // target on the pose: bearing taken as zero
    err = ((dx == 0 && dy == 0) ? 16'd0 : cz[31:16]) - head_angle;
    pfull = gp * $signed({1'b0, ddog_pkg::TWO_PI_Q29});
    bb = $signed({11'd0, base_drive, 45'd0});
    bl = bb - pfull;
    br = bb + pfull;
  end

  assign sts.tick_run = (op == ddog_pkg::OP_TICK) && run_mode;
  assign sts.step_last = (it == 5'(CORDIC_STEPS - 1));
  assign sts.arrived = (64'(ax) < 64'h8000_0000) && (64'(ay) < 64'h8000_0000) &&
                       (dsq < (2*DW)'(limsq));

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0; pos_y <= '0; aim_x <= '0; aim_y <= '0;
      head_angle <= '0; pend_l <= '0; pend_r <= '0;
      run_mode <= 1'b0; drv_l <= '0; drv_r <= '0; reach <= 1'b0;
      op <= ddog_pkg::OP_TICK; it <= '0;
      travel <= '0; dang <= '0; cx <= '0; cy <= '0; cz <= '0; flip <= 1'b0;
      mx <= '0; my <= '0; dx <= '0; dy <= '0; gp <= '0;
    end else begin
      if (cmd.load_item) begin
        op <= opcode;
        reach <= 1'b0;
        if (opcode == ddog_pkg::OP_TICK) begin
          pend_l <= sum_l[16] ? 16'hFFFF : sum_l[15:0];
          pend_r <= sum_r[16] ? 16'hFFFF : sum_r[15:0];
        end else if (opcode == ddog_pkg::OP_MOVE) begin
          aim_x <= AW'(goal_x);
          aim_y <= AW'(goal_y);
        end
      end
      if (cmd.simple) begin
        if (op == ddog_pkg::OP_MOVE) begin
          run_mode <= 1'b1;
        end else if (op != ddog_pkg::OP_TICK) begin
          run_mode <= 1'b0; drv_l <= '0; drv_r <= '0;
          if (op == ddog_pkg::OP_RESET_POSE) begin
            pos_x <= '0; pos_y <= '0; head_angle <= '0;
          end
        end
      end
      if (cmd.start_move) begin
        travel <= 28'((29'(pend_l) * 29'(tick_length) +
                       29'(pend_r) * 29'(tick_length)) >> 1);
        dang <= ($signed({13'd0, pend_r}) - $signed({13'd0, pend_l})) *
                $signed({17'd0, turn_per_tick});
        pend_l <= '0; pend_r <= '0;
      end
      if (cmd.sc_init) begin
        it <= '0;
        if (z0 > 34'sd1073741824) begin
          cz <= z0 - 34'sd2147483648; flip <= 1'b1;
        end else if (z0 < -34'sd1073741824) begin
          cz <= z0 + 34'sd2147483648; flip <= 1'b1;
        end else begin
          cz <= z0; flip <= 1'b0;
        end
        cx <= CW'(ddog_pkg::KGAIN_Q30);
        cy <= '0;
      end
      if (cmd.sc_step) begin
        it <= it + 5'd1;
        if (cz >= 0) begin
          cx <= cx - shy; cy <= cy + shx; cz <= cz - $signed({2'b0, at_k});
        end else begin
          cx <= cx + shy; cy <= cy - shx; cz <= cz + $signed({2'b0, at_k});
        end
      end
      if (cmd.mul_pos) begin
        mx <= $signed({1'b0, travel}) * (flip ? -cs : cs);
        my <= $signed({1'b0, travel}) * (flip ? -sn : sn);
      end
      if (cmd.upd_pos) begin
        pos_x <= (pxs > SW'(PMAX)) ? PMAX : (pxs < SW'(PMIN)) ? PMIN : pxs[POS_BITS-1:0];
        pos_y <= (pys > SW'(PMAX)) ? PMAX : (pys < SW'(PMIN)) ? PMIN : pys[POS_BITS-1:0];
        head_angle <= head_angle + dang[15:0];
      end
      if (cmd.diff_pos) begin
        dx <= DW'(aim_x) - DW'(pos_x);
        dy <= DW'(aim_y) - DW'(pos_y);
      end
      if (cmd.arrive) begin
        drv_l <= '0; drv_r <= '0; run_mode <= 1'b0; reach <= 1'b1;
      end
      if (cmd.at_init) begin
        it <= '0;
        // target behind: mirror the vector and start from half a turn
        if (dx < 0) begin
          cx <= -vx; cy <= -vy; cz <= 34'sd2147483648;
        end else begin
          cx <= vx; cy <= vy; cz <= '0;
        end
      end
      if (cmd.at_step) begin
        it <= it + 5'd1;
        if (cy >= 0) begin
          cx <= cx + shy; cy <= cy - shx; cz <= cz + $signed({2'b0, at_k});
        end else begin
          cx <= cx - shy; cy <= cy + shx; cz <= cz - $signed({2'b0, at_k});
        end
      end
      if (cmd.steer_mul) begin
        gp <= $signed({1'b0, steer_gain}) * $signed(err);
      end
      if (cmd.steer_fin) begin
        drv_l <= sat_drv(bl);
        drv_r <= sat_drv(br);
      end
    end
  end

  assign left_drive = drv_l;
  assign right_drive = drv_r;
  assign pose_x = 24'(pos_x);
  assign pose_y = 24'(pos_y);
  assign heading = head_angle;
  assign moving = run_mode;
  assign reached = reach;

endmodule

### sv/diff_drive_odometry_goto.sv
// Differential-drive odometry with go-to-goal steering, top level.
// Stop, move_to, reset pose and idle ticks go straight from decode to the result;
// a moving tick makes two passes through one iterative CORDIC (sin/cos, then
// atan2), and only the sin/cos pass when the target is reached.
// One item at a time: the next item is accepted in the cycle after the result is taken.
// Synchronous reset clears pose, target, drives and pending counts, loads register defaults.
module diff_drive_odometry_goto #(
  parameter int CORDIC_STEPS = ddog_pkg::CORDIC_STEPS_DEF,
  parameter int POS_BITS = ddog_pkg::POS_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [11:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic [7:0]         left_ticks,
  input  logic [7:0]         right_ticks,
  input  logic signed [23:0] goal_x,
  input  logic signed [23:0] goal_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [8:0]  left_drive,
  output logic signed [8:0]  right_drive,
  output logic signed [23:0] pose_x,
  output logic signed [23:0] pose_y,
  output logic signed [15:0] heading,
  output logic               moving,
  output logic               reached
);

  ddog_pkg::ddog_cmd_t cmd;
  ddog_pkg::ddog_sts_t sts;

  ddog_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  ddog_dp #(.CORDIC_STEPS(CORDIC_STEPS), .POS_BITS(POS_BITS)) u_dp (
    .clk, .rst, .cmd, .sts, .cfg_we, .cfg_index, .cfg_data,
    .opcode, .left_ticks, .right_ticks, .goal_x, .goal_y,
    .left_drive, .right_drive, .pose_x, .pose_y, .heading, .moving, .reached
  );

endmodule
